>>> src/two_axis_light_tracker_pid_assert.svh
// assertion macros for the two-axis light tracker
// expects clk_i and rst_ni in the scope of use
`ifndef TWO_AXIS_LIGHT_TRACKER_PID_ASSERT_SVH
`define TWO_AXIS_LIGHT_TRACKER_PID_ASSERT_SVH

// property checked on every clock edge outside reset
`define TATPID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tatpid: assertion failed");

// condition in one cycle implies a condition in the next
`define TATPID_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tatpid: sequence assertion failed");

`endif

>>> src/tatpid_pkg.sv
// shared types and constants for the two-axis light tracker
// no dependencies
package tatpid_pkg;

  localparam int SampleW = 12;
  localparam int ErrW    = 14;
  localparam int DriveW  = 24;
  localparam int GainW   = 8;
  localparam int BandW   = 23;
  localparam int OffsW   = 13;
  localparam int DiffW   = ((SampleW + 1 > OffsW) ? SampleW + 1 : OffsW) + 1;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgPropGain   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIntegGain  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDerivGain  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDeadBand   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHorizOffs  = 3'd4;

  localparam logic [GainW-1:0]        PropGainRst  = 8'd10;
  localparam logic [GainW-1:0]        IntegGainRst = 8'd1;
  localparam logic [GainW-1:0]        DerivGainRst = 8'd1;
  localparam logic [BandW-1:0]        DeadBandRst  = 23'd4000;
  localparam logic signed [OffsW-1:0] HorizOffsRst = 13'sd250;

  typedef struct packed {
    logic [SampleW-1:0] sensor_top_left;
    logic [SampleW-1:0] sensor_top_right;
    logic [SampleW-1:0] sensor_bottom_left;
    logic [SampleW-1:0] sensor_bottom_right;
  } in_item_t;

  typedef struct packed {
    logic signed [DriveW-1:0] horizontal_drive;
    logic signed [DriveW-1:0] vertical_drive;
  } out_item_t;

  typedef struct packed {
    logic mid_en;
    logic out_en;
  } stage_ctrl_t;

endpackage

>>> src/tatpid_axis.sv
// one PID axis: error clamp, integrator and last error, then gains,
// deadband and drive clamp; uses tatpid_pkg
module tatpid_axis (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  tatpid_pkg::stage_ctrl_t                   ctrl_i,
  input  logic signed [tatpid_pkg::DiffW-1:0]       diff_i,
  input  logic        [tatpid_pkg::GainW-1:0]       prop_gain_i,
  input  logic        [tatpid_pkg::GainW-1:0]       integ_gain_i,
  input  logic        [tatpid_pkg::GainW-1:0]       deriv_gain_i,
  input  logic        [tatpid_pkg::BandW-1:0]       dead_band_i,
  output logic signed [tatpid_pkg::DriveW-1:0]      drive_o
);

  localparam int ErrW   = tatpid_pkg::ErrW;
  localparam int DriveW = tatpid_pkg::DriveW;
  localparam int DiffW  = tatpid_pkg::DiffW;
  localparam int GainW  = tatpid_pkg::GainW;
  localparam int PW     = GainW + 1 + ErrW;
  localparam int IW     = GainW + 1 + DriveW;
  localparam int DW     = GainW + 1 + ErrW + 1;
  localparam int RawW   = IW + 2;

  localparam logic signed [DiffW-1:0]  DiffHi  = DiffW'((2 ** (ErrW - 1)) - 1);
  localparam logic signed [DiffW-1:0]  DiffLo  = DiffW'(-(2 ** (ErrW - 1)));
  localparam logic signed [DriveW:0]   AccHi   = (DriveW + 1)'((2 ** (DriveW - 1)) - 1);
  localparam logic signed [DriveW:0]   AccLo   = (DriveW + 1)'(-(2 ** (DriveW - 1)));
  localparam logic signed [RawW-1:0]   RawHi   = RawW'((2 ** (DriveW - 1)) - 1);
  localparam logic signed [RawW-1:0]   RawLo   = RawW'(-(2 ** (DriveW - 1)));

  logic signed [DriveW-1:0] integ_q, integ_d;
  logic signed [ErrW-1:0]   last_err_q;
  logic signed [ErrW-1:0]   err;
  logic signed [DriveW:0]   acc_sum;
  logic signed [ErrW:0]     der;

  logic signed [ErrW-1:0]   err_q;
  logic signed [DriveW-1:0] acc_q;
  logic signed [ErrW:0]     der_q;

  logic signed [GainW:0]    pg_s, ig_s, dg_s;
  logic signed [PW-1:0]     prod_p;
  logic signed [IW-1:0]     prod_i;
  logic signed [DW-1:0]     prod_d;
  logic signed [RawW-1:0]   raw;
  logic signed [RawW-1:0]   band_s;
  logic signed [DriveW-1:0] drive_d, drive_q;

  // error clamp, integrator and derivative
  always_comb begin
    if (diff_i > DiffHi) begin
      err = DiffHi[ErrW-1:0];
    end else if (diff_i < DiffLo) begin
      err = DiffLo[ErrW-1:0];
    end else begin
      err = diff_i[ErrW-1:0];
    end
    acc_sum = (DriveW + 1)'(integ_q) + (DriveW + 1)'(err);
    if (acc_sum > AccHi) begin
      integ_d = AccHi[DriveW-1:0];
    end else if (acc_sum < AccLo) begin
      integ_d = AccLo[DriveW-1:0];
    end else begin
      integ_d = acc_sum[DriveW-1:0];
    end
    der = (ErrW + 1)'(err) - (ErrW + 1)'(last_err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      last_err_q <= '0;
    end else if (ctrl_i.mid_en) begin
      integ_q    <= integ_d;
      last_err_q <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mid_en) begin
      err_q <= err;
      acc_q <= integ_d;
      der_q <= der;
    end
  end

  // gain products, deadband and drive clamp
  always_comb begin
    pg_s   = $signed({1'b0, prop_gain_i});
    ig_s   = $signed({1'b0, integ_gain_i});
    dg_s   = $signed({1'b0, deriv_gain_i});
    prod_p = PW'(pg_s) * PW'(err_q);
    prod_i = IW'(ig_s) * IW'(acc_q);
    prod_d = DW'(dg_s) * DW'(der_q);
    raw    = RawW'(prod_p) + RawW'(prod_i) + RawW'(prod_d);
    band_s = $signed(RawW'(dead_band_i));
    if ((raw < band_s) && (raw > -band_s)) begin
      drive_d = '0;
    end else if (raw > RawHi) begin
      drive_d = RawHi[DriveW-1:0];
    end else if (raw < RawLo) begin
      drive_d = RawLo[DriveW-1:0];
    end else begin
      drive_d = raw[DriveW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_en) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

>>> src/two_axis_light_tracker_pid.sv
// top level of the two-axis light tracker: input register, pair averages,
// two PID axes and handshake control; uses tatpid_pkg, tatpid_axis and the assert header
//
//   channel  direction  handshake                fields
//   in       input      in_valid_i / in_ready_o   in_item_i (four light samples)
//   out      output     out_valid_o / out_ready_i out_item_o (two drives)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle unless the output stalls; data passes in, mid and out registers
// the rate is set by the integrator and last error update
// each of the three stages moves on when the stage after it is empty or moving
// a stall at the output backs up stage by stage to in_ready_o
// reset clears valid bits, integrators and last errors, loads config defaults
`include "two_axis_light_tracker_pid_assert.svh"

module two_axis_light_tracker_pid (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  tatpid_pkg::in_item_t                 in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tatpid_pkg::out_item_t                out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tatpid_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tatpid_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int SampleW = tatpid_pkg::SampleW;
  localparam int DiffW   = tatpid_pkg::DiffW;
  localparam int GainW   = tatpid_pkg::GainW;
  localparam int BandW   = tatpid_pkg::BandW;
  localparam int OffsW   = tatpid_pkg::OffsW;

  logic [GainW-1:0]        prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [BandW-1:0]        dead_band_q;
  logic signed [OffsW-1:0] horiz_offs_q;

  logic                    in_valid_q, in_valid_d;
  logic                    mid_valid_q, mid_valid_d;
  logic                    out_valid_q, out_valid_d;
  logic                    en_mid, en_out;
  tatpid_pkg::in_item_t    in_q;
  tatpid_pkg::stage_ctrl_t ctrl;

  logic [SampleW:0]        sum_top, sum_bot, sum_left, sum_right;
  logic signed [DiffW-1:0] diff_h, diff_v;
  logic signed [tatpid_pkg::DriveW-1:0] drive_h, drive_v;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= tatpid_pkg::PropGainRst;
      integ_gain_q <= tatpid_pkg::IntegGainRst;
      deriv_gain_q <= tatpid_pkg::DerivGainRst;
      dead_band_q  <= tatpid_pkg::DeadBandRst;
      horiz_offs_q <= tatpid_pkg::HorizOffsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tatpid_pkg::CfgPropGain:  prop_gain_q  <= cfg_data_i[GainW-1:0];
        tatpid_pkg::CfgIntegGain: integ_gain_q <= cfg_data_i[GainW-1:0];
        tatpid_pkg::CfgDerivGain: deriv_gain_q <= cfg_data_i[GainW-1:0];
        tatpid_pkg::CfgDeadBand:  dead_band_q  <= cfg_data_i[BandW-1:0];
        tatpid_pkg::CfgHorizOffs: horiz_offs_q <= $signed(cfg_data_i[OffsW-1:0]);
        default: ;
      endcase
    end
  end

  // stage control
  always_comb begin
    en_out      = !out_valid_q || out_ready_i;
    en_mid      = !mid_valid_q || en_out;
    in_ready_o  = !in_valid_q || en_mid;
    in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
    mid_valid_d = en_mid ? in_valid_q : mid_valid_q;
    out_valid_d = en_out ? mid_valid_q : out_valid_q;
    ctrl.mid_en = en_mid && in_valid_q;
    ctrl.out_en = en_out && mid_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      mid_valid_q <= mid_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // truncated pair averages and axis differences, the horizontal one less its offset
  always_comb begin
    sum_top   = {1'b0, in_q.sensor_top_left}    + {1'b0, in_q.sensor_top_right};
    sum_bot   = {1'b0, in_q.sensor_bottom_left} + {1'b0, in_q.sensor_bottom_right};
    sum_left  = {1'b0, in_q.sensor_top_left}    + {1'b0, in_q.sensor_bottom_left};
    sum_right = {1'b0, in_q.sensor_top_right}   + {1'b0, in_q.sensor_bottom_right};
    diff_h    = $signed(DiffW'(sum_right[SampleW:1])) - $signed(DiffW'(sum_left[SampleW:1]))
              - DiffW'(horiz_offs_q);
    diff_v    = $signed(DiffW'(sum_top[SampleW:1])) - $signed(DiffW'(sum_bot[SampleW:1]));
  end

  tatpid_axis u_axis_h (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .diff_i       (diff_h),
    .prop_gain_i  (prop_gain_q),
    .integ_gain_i (integ_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .dead_band_i  (dead_band_q),
    .drive_o      (drive_h)
  );

  tatpid_axis u_axis_v (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .diff_i       (diff_v),
    .prop_gain_i  (prop_gain_q),
    .integ_gain_i (integ_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .dead_band_i  (dead_band_q),
    .drive_o      (drive_v)
  );

  assign out_valid_o                 = out_valid_q;
  assign out_item_o.horizontal_drive = drive_h;
  assign out_item_o.vertical_drive   = drive_v;

  `TATPID_ASSERT(a_ready_follows_out, out_ready_i |-> in_ready_o)
  `TATPID_ASSERT(a_full_stall_blocks, (in_valid_q && !en_mid) |-> !in_ready_o)
  `TATPID_ASSERT_NEXT(a_mid_held, out_valid_o && !out_ready_i && mid_valid_q, mid_valid_q)
  `TATPID_ASSERT_NEXT(a_mid_loaded, ctrl.mid_en, mid_valid_q)
  `TATPID_ASSERT(a_result_from_mid, $rose(out_valid_o) |-> $past(mid_valid_q))

endmodule
